>>> sv/rcd_pkg.sv
`timescale 1ns / 1ps

package rcd_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PARAM_W  = 5;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    RIDX_RICE_PARAM  = 1'b0,
    RIDX_VALUE_COUNT = 1'b1
  } reg_idx_e;

  localparam logic [COUNT_W-1:0] VALUE_COUNT_RST = 16'd2048;

  // controller -> datapath
  typedef struct packed {
    logic load_word;
    logic step;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;
    logic blk;
    logic last_bit;
    logic pend_valid;
    logic load_ok;
  } stat_t;

  // zigzag: even u -> u/2, odd u -> -(u+1)/2 == ~(u>>1)
  function automatic logic [DATA_W-1:0] zigzag(input logic [DATA_W-1:0] u);
    zigzag = {1'b0, u[DATA_W-1:1]} ^ {DATA_W{u[0]}};
  endfunction

endpackage

>>> sv/rice_code_decoder_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// --------+-----------+------------------------+----------------------------------
// input   | in        | in_valid_i / in_stall_o | code_word_i[31:0]
// output  | out       | out_valid_o / out_stall_i | value_o[31:0] s, word_end_o, block_end_o
// config  | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i[15:0]
//
// A word is accepted, then the bit-serial scanner takes one code bit per cycle unless
// an output stall holds it, and then the last value of the word is released. A block
// end cuts the scan short. Output stalls hold the scan when a new value is ready while
// one is pending and the output register is still full.
// Reset (rst_ni low, async) clears the decode state; rice_param = 0, value_count = 2048.
// Each value is held back one step so word_end can be set on the last value of a word.

module rice_code_decoder_top #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config
  input  logic                              cfg_we_i,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rcd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // code words in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rcd_pkg::DATA_W-1:0]        code_word_i,
  // decoded values out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rcd_pkg::DATA_W-1:0] value_o,
  output logic                              word_end_o,
  output logic                              block_end_o
);
  import rcd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: idle / scan bits / release last value
  rcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // bit scanner, quotient/remainder build, block count, output register
  rcd_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .code_word_i (code_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .word_end_o  (word_end_o),
    .block_end_o (block_end_o)
  );

endmodule

>>> sv/rcd_ctrl.sv
`timescale 1ns / 1ps

module rcd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rcd_pkg::stat_t stat_i,
  output rcd_pkg::cmd_t  cmd_o
);
  import rcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_word = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // hold the bit when a new value meets a pending one and the output is full and stalled
        if (!(stat_i.emit && stat_i.pend_valid && !stat_i.load_ok)) begin
          cmd_o.step = 1'b1;
          if (stat_i.last_bit || (stat_i.emit && stat_i.blk)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (stat_i.load_ok) begin
          cmd_o.flush = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/rcd_datapath.sv
`timescale 1ns / 1ps

module rcd_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rcd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [rcd_pkg::DATA_W-1:0]      code_word_i,
  input  rcd_pkg::cmd_t                   cmd_i,
  output rcd_pkg::stat_t                  stat_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [rcd_pkg::DATA_W-1:0] value_o,
  output logic                            word_end_o,
  output logic                            block_end_o
);
  import rcd_pkg::*;

  localparam int unsigned CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_BITS - 1);

  // configuration
  logic [PARAM_W-1:0] rice_param_q;
  logic [COUNT_W-1:0] value_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rice_param_q  <= '0;
      value_count_q <= VALUE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RIDX_RICE_PARAM:  rice_param_q  <= cfg_wdata_i[PARAM_W-1:0];
        RIDX_VALUE_COUNT: value_count_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // decode state
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [CNT_W-1:0]     bcnt_q, bcnt_d;
  logic                 phase_q, phase_d;
  logic [DATA_W-1:0]    quot_q, quot_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [PARAM_W-1:0]   bl_q, bl_d;
  logic [COUNT_W-1:0]   vd_q, vd_d;
  // pending value: held until it is known whether it is the last of the word
  logic                 pend_v_q, pend_v_d;
  logic [DATA_W-1:0]    pend_val_q, pend_val_d;
  logic                 pend_blk_q, pend_blk_d;
  // output register
  logic                 out_v_q, out_v_d;
  logic [DATA_W-1:0]    out_val_q, out_val_d;
  logic                 out_we_q, out_we_d;
  logic                 out_be_q, out_be_d;

  logic [63:0]          cw_ext;
  logic                 cur_bit;
  logic [DATA_W-1:0]    quot_sh;
  logic [DATA_W-1:0]    rem_sh;
  logic [PARAM_W-1:0]   bl_dec;
  logic                 emit;
  logic [DATA_W-1:0]    u_val;
  logic [COUNT_W-1:0]   limit;
  logic [COUNT_W-1:0]   vd_inc;
  logic                 blk;
  logic                 load_ok;

  assign cw_ext  = {32'd0, code_word_i};
  assign cur_bit = word_q[0];
  assign quot_sh = quot_q << rice_param_q;
  assign rem_sh  = {rem_q[DATA_W-2:0], cur_bit};
  assign bl_dec  = (bl_q != '0) ? bl_q - PARAM_W'(1) : '0;
  assign limit   = (value_count_q != '0) ? value_count_q : COUNT_W'(1);
  assign vd_inc  = vd_q + COUNT_W'(1);
  assign blk     = (vd_inc >= limit) || (vd_inc == '0);
  assign load_ok = !out_v_q || !out_stall_i;

  always_comb begin
    if (!phase_q) begin
      emit  = !cur_bit && (rice_param_q == '0);
      u_val = quot_q;
    end else begin
      emit  = (bl_dec == '0);
      u_val = quot_q | rem_sh;
    end
  end

  always_comb begin
    stat_o.emit       = emit;
    stat_o.blk        = blk;
    stat_o.last_bit   = (bcnt_q == LAST_BIT);
    stat_o.pend_valid = pend_v_q;
    stat_o.load_ok    = load_ok;
  end

  always_comb begin
    word_d     = word_q;
    bcnt_d     = bcnt_q;
    phase_d    = phase_q;
    quot_d     = quot_q;
    rem_d      = rem_q;
    bl_d       = bl_q;
    vd_d       = vd_q;
    pend_v_d   = pend_v_q;
    pend_val_d = pend_val_q;
    pend_blk_d = pend_blk_q;
    out_v_d    = out_v_q && out_stall_i;
    out_val_d  = out_val_q;
    out_we_d   = out_we_q;
    out_be_d   = out_be_q;

    if (cmd_i.load_word) begin
      word_d = cw_ext[WORD_BITS-1:0];
      bcnt_d = '0;
    end

    if (cmd_i.step) begin
      word_d = word_q >> 1;
      bcnt_d = bcnt_q + CNT_W'(1);
      if (!phase_q) begin
        if (cur_bit) begin
          quot_d = quot_q + DATA_W'(1);
        end else begin
          quot_d  = quot_sh;
          rem_d   = '0;
          phase_d = 1'b1;
          bl_d    = rice_param_q;
        end
      end else begin
        rem_d = rem_sh;
        bl_d  = bl_dec;
      end
      if (emit) begin
        quot_d  = '0;
        rem_d   = '0;
        bl_d    = '0;
        phase_d = 1'b0;
        vd_d    = blk ? '0 : vd_inc;
        if (pend_v_q) begin
          out_v_d   = 1'b1;
          out_val_d = pend_val_q;
          out_we_d  = 1'b0;
          out_be_d  = pend_blk_q;
        end
        pend_v_d   = 1'b1;
        pend_val_d = zigzag(u_val);
        pend_blk_d = blk;
      end
    end

    if (cmd_i.flush) begin
      out_v_d   = 1'b1;
      out_val_d = pend_val_q;
      out_we_d  = 1'b1;
      out_be_d  = pend_blk_q;
      pend_v_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q   <= '0;
      phase_q  <= 1'b0;
      quot_q   <= '0;
      rem_q    <= '0;
      bl_q     <= '0;
      vd_q     <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      bcnt_q   <= bcnt_d;
      phase_q  <= phase_d;
      quot_q   <= quot_d;
      rem_q    <= rem_d;
      bl_q     <= bl_d;
      vd_q     <= vd_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    pend_val_q <= pend_val_d;
    pend_blk_q <= pend_blk_d;
    out_val_q  <= out_val_d;
    out_we_q   <= out_we_d;
    out_be_q   <= out_be_d;
  end

  assign out_valid_o = out_v_q;
  assign value_o     = signed'(out_val_q);
  assign word_end_o  = out_we_q;
  assign block_end_o = out_be_q;

endmodule
